FILE: sv/ebp_pkg.sv
// Shared types, constants and helper functions for the escaped byte printer.
package ebp_pkg;

    // Character codes
    localparam logic [7:0] NL_CHAR  = 8'h0A;
    localparam logic [7:0] ESC_CHAR = 8'h5C;

    // Configuration register indexes and reset values
    localparam logic [7:0]  REG_LINE_LIMIT    = 8'd0;
    localparam logic [7:0]  REG_RADIX_MODE    = 8'd1;
    localparam logic [15:0] LINE_LIMIT_RESET  = 16'd79;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    // Longest run of characters one byte can cause
    localparam int RUN_MAX   = 6;
    localparam int IDX_W     = $clog2(RUN_MAX);
    localparam int LEN_W     = $clog2(RUN_MAX + 1);

    // Queue of classified runs between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        RADIX_HEX   = 2'd0,
        RADIX_OCT   = 2'd1,
        RADIX_DEC   = 2'd2,
        RADIX_DEC_I = 2'd3
    } radix_t;

    // One classified input byte: its characters in order and how many there are
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [LEN_W-1:0]        len;
    } run_t;

    // Head of the run queue as seen by the back end
    typedef struct packed {
        logic valid;
        run_t run;
    } head_t;

    // Lowercase ASCII digit for a value 0..15
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'h0, d};
        end
        else
        begin
            c = 8'h61 + {4'h0, d} - 8'd10;
        end
        return c;
    endfunction

    // Letter that follows the backslash
    function automatic logic [7:0] radix_letter(input radix_t r);
        logic [7:0] c;
        case (r)
            RADIX_HEX:   c = 8'h78;
            RADIX_OCT:   c = 8'h6F;
            RADIX_DEC:   c = 8'h64;
            RADIX_DEC_I: c = 8'h69;
            default:     c = 8'h78;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/ebp_front.sv
// Front end: accepts bytes, tracks the column, and builds each byte's character run.
module ebp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                q_full,
    input  logic [7:0]          in_byte,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                q_push,
    output ebp_pkg::run_t       q_run
);

    logic [15:0]     limit_reg;
    logic [15:0]     count_reg;
    logic [15:0]     count_next;
    ebp_pkg::radix_t radix_reg;

    logic       accept;
    logic       is_nl;
    logic       wrap;
    logic       passes;
    logic [3:0] dig2;
    logic [3:0] dig1;
    logic [3:0] dig0;
    logic [1:0] ndig;
    logic [7:0] rem_h;
    logic [6:0] rem_t;
    logic [14:0] tens_prod;
    logic [3:0] tens;
    logic [6:0] tens_x10;

    assign accept = push && !q_full;
    assign q_push = accept;
    assign is_nl  = (in_byte == ebp_pkg::NL_CHAR);
    assign wrap   = (count_reg >= limit_reg) && !is_nl;
    assign passes = in_byte inside {[8'h09:8'h0D], [8'h20:8'h7E]};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ebp_pkg::LINE_LIMIT_RESET;
            radix_reg <= ebp_pkg::RADIX_HEX;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ebp_pkg::REG_LINE_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
            else if (cfg_index == ebp_pkg::REG_RADIX_MODE)
            begin
                radix_reg <= ebp_pkg::radix_t'(cfg_data[1:0]);
            end
        end
    end

    // Column counter: newline clears, anything else adds one (after a wrap, starts at one)
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (is_nl)
            begin
                count_next = '0;
            end
            else if (wrap)
            begin
                count_next = 16'd1;
            end
            else if (count_reg != ebp_pkg::COUNT_MAX)
            begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Decimal split: hundreds by compare, tens by reciprocal multiply (valid below 1029)
    always_comb
    begin
        if (in_byte >= 8'd200)
        begin
            rem_h = in_byte - 8'd200;
        end
        else if (in_byte >= 8'd100)
        begin
            rem_h = in_byte - 8'd100;
        end
        else
        begin
            rem_h = in_byte;
        end
        rem_t     = rem_h[6:0];
        tens_prod = {8'h00, rem_t} * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = {3'b000, tens} * 7'd10;
    end

    // Digits of the escape, most significant first, and their count
    always_comb
    begin
        dig2 = '0;
        dig1 = '0;
        dig0 = '0;
        ndig = 2'd1;
        case (radix_reg)
            ebp_pkg::RADIX_HEX:
            begin
                dig1 = in_byte[7:4];
                dig0 = in_byte[3:0];
                ndig = (dig1 != 4'd0) ? 2'd2 : 2'd1;
            end
            ebp_pkg::RADIX_OCT:
            begin
                dig2 = {2'b00, in_byte[7:6]};
                dig1 = {1'b0, in_byte[5:3]};
                dig0 = {1'b0, in_byte[2:0]};
                ndig = (dig2 != 4'd0) ? 2'd3 : ((dig1 != 4'd0) ? 2'd2 : 2'd1);
            end
            default:
            begin
                dig2 = (in_byte >= 8'd200) ? 4'd2 : ((in_byte >= 8'd100) ? 4'd1 : 4'd0);
                dig1 = tens;
                dig0 = rem_t[3:0] - tens_x10[3:0];
                ndig = (dig2 != 4'd0) ? 2'd3 : ((dig1 != 4'd0) ? 2'd2 : 2'd1);
            end
        endcase
    end

    // Assemble the run: optional newline, then the byte or its escape
    always_comb
    begin
        logic [ebp_pkg::IDX_W-1:0] pos;
        pos         = '0;
        q_run.chars = '0;
        q_run.len   = '0;
        if (wrap)
        begin
            q_run.chars[0] = ebp_pkg::NL_CHAR;
            pos            = 3'd1;
        end
        if (passes)
        begin
            q_run.chars[pos] = in_byte;
            q_run.len        = pos + 3'd1;
        end
        else
        begin
            q_run.chars[pos]        = ebp_pkg::ESC_CHAR;
            q_run.chars[pos + 3'd1] = ebp_pkg::radix_letter(radix_reg);
            pos                     = pos + 3'd2;
            case (ndig)
                2'd3:
                begin
                    q_run.chars[pos]        = ebp_pkg::digit_char(dig2);
                    q_run.chars[pos + 3'd1] = ebp_pkg::digit_char(dig1);
                    q_run.chars[pos + 3'd2] = ebp_pkg::digit_char(dig0);
                    q_run.len               = pos + 3'd3;
                end
                2'd2:
                begin
                    q_run.chars[pos]        = ebp_pkg::digit_char(dig1);
                    q_run.chars[pos + 3'd1] = ebp_pkg::digit_char(dig0);
                    q_run.len               = pos + 3'd2;
                end
                default:
                begin
                    q_run.chars[pos] = ebp_pkg::digit_char(dig0);
                    q_run.len        = pos + 3'd1;
                end
            endcase
        end
    end

endmodule

FILE: sv/ebp_queue.sv
// Short queue of classified runs between the front and back ends.
module ebp_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_push,
    input  ebp_pkg::run_t q_run,
    input  logic          q_pop,
    output logic          q_full,
    output ebp_pkg::head_t head
);

    ebp_pkg::run_t                  store_reg [ebp_pkg::QUEUE_DEPTH];
    logic [ebp_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ebp_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ebp_pkg::QCNT_W-1:0]     cnt_reg;
    logic [ebp_pkg::QCNT_W-1:0]     cnt_next;

    assign q_full     = (cnt_reg == ebp_pkg::QCNT_W'(ebp_pkg::QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.run   = store_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            store_reg[wr_ptr_reg] <= q_run;
        end
    end

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !q_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/ebp_back.sv
// Back end: head run to output register, one character per cycle while pop keeps up.
module ebp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  ebp_pkg::head_t head,
    input  logic           pop,
    output logic           q_pop,
    output logic           empty,
    output logic [7:0]     out_char,
    output logic           run_last
);

    logic [ebp_pkg::IDX_W-1:0] idx_reg;
    logic [ebp_pkg::IDX_W-1:0] idx_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic [7:0]                char_reg;
    logic                      last_reg;

    logic out_xfer;
    logic room;
    logic emit;
    logic at_last;

    assign out_xfer = pop && valid_reg;
    assign room     = !valid_reg || out_xfer;
    assign emit     = room && head.valid;
    assign at_last  = (ebp_pkg::LEN_W'(idx_reg) == (head.run.len - ebp_pkg::LEN_W'(1)));
    assign q_pop    = emit && at_last;

    assign empty    = !valid_reg;
    assign out_char = char_reg;
    assign run_last = last_reg;

    // Sequencer and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_xfer)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= head.run.chars[idx_reg];
            last_reg <= at_last;
        end
    end

endmodule

FILE: sv/escaped_byte_printer_line_wrap_core.sv
// Top level of the escaped byte printer with line wrap.
//
// Bytes enter through a push/full queue port and leave as ASCII characters through an
// empty/pop port, with run_last marking the final character of each byte. Tab through
// carriage return and 0x20..0x7E pass through; any other byte prints as a backslash, a radix
// letter and its digits. A newline is inserted ahead of any byte but a newline once the
// column count has reached line_limit. The back end emits one character per cycle, while
// pop keeps up, from a single output register; a passing byte gives one character, an
// escape three to five, and an inserted newline one more. A four-entry run queue lets the
// input side keep accepting while the back end works through an escape. The configuration
// port is always ready; write it only while the block is idle.
module escaped_byte_printer_line_wrap_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        run_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic           q_push;
    logic           q_pop;
    ebp_pkg::run_t  q_run;
    ebp_pkg::head_t head;

    assign cfg_ready = 1'b1;

    ebp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (full),
        .in_byte   (in_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_run     (q_run)
    );

    ebp_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_run  (q_run),
        .q_pop  (q_pop),
        .q_full (full),
        .head   (head)
    );

    ebp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .q_pop    (q_pop),
        .empty    (empty),
        .out_char (out_char),
        .run_last (run_last)
    );

`ifndef NO_ASSERTIONS
    // The back end only retires a run that is actually queued
    a_pop_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> head.valid)
        else $error("run retired from an empty queue");

    // A queued run always has between one and six characters
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (head.run.len != '0 && head.run.len <= 3'd6))
        else $error("queued run has a bad length");

    // A full queue cannot be empty at its head
    a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head.valid)
        else $error("queue full with no head entry");
`endif

endmodule
